@@ hw/rtl/adri_pkg.sv @@
// Shared types, widths and constants for the dead-reckoning integrator.
package adri_pkg;

   localparam int CALIB_SAMPLES_DEF = 64;

   localparam int ACCEL_W     = 16;
   localparam int VEL_W       = 32;
   localparam int POS_W       = 48;
   localparam int DEADBAND_W  = 15;
   localparam int ZRUN_W      = 8;
   localparam int OPCODE_W    = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [DEADBAND_W-1:0] DEADBAND_RST   = 15'd100;
   localparam logic [ZRUN_W-1:0]     ZRUN_LIMIT_RST = 8'd5;

   typedef enum logic [OPCODE_W-1:0] {
      OP_MEASURE   = 2'd0,
      OP_CALIBRATE = 2'd1,
      OP_CLEAR     = 2'd2
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEADBAND       = 2'd0,
      CSR_ZERO_RUN_LIMIT = 2'd1
   } csr_index_type;

endpackage

@@ hw/rtl/accel_dead_reckoning_integrator.sv @@
// Flow: a request transfer loads the input register; its result moves into the
//    output register once that register is free (empty or not stalled).
// Throughput: one item per cycle unless the output stalls; conditioning, velocity,
//    position and offset update all resolve in the single stage between input and output register.
// Reset: synchronous, active high; clears motion and calibration state and the
//    offset, and sets deadband to 100 and zero-run limit to 5.
module accel_dead_reckoning_integrator #(
   parameter int CALIB_SAMPLES = adri_pkg::CALIB_SAMPLES_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [adri_pkg::OPCODE_W-1:0]          req_opcode,
   input  logic signed [adri_pkg::ACCEL_W-1:0]    req_accel_raw,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [adri_pkg::ACCEL_W-1:0]    rsp_accel_clean,
   output logic signed [adri_pkg::VEL_W-1:0]      rsp_velocity,
   output logic signed [adri_pkg::POS_W-1:0]      rsp_position,
   output logic                                   rsp_stationary,
   output logic                                   rsp_calib_done,
   output logic signed [adri_pkg::ACCEL_W-1:0]    rsp_offset_now,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [adri_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [adri_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int AW      = adri_pkg::ACCEL_W;
   localparam int VW      = adri_pkg::VEL_W;
   localparam int PW      = adri_pkg::POS_W;
   localparam int ZW      = adri_pkg::ZRUN_W;
   localparam int DW      = adri_pkg::DEADBAND_W;
   localparam int LOG_N   = $clog2(CALIB_SAMPLES);
   localparam int CNT_W   = LOG_N;
   localparam int SUM_W   = AW + LOG_N;
   localparam int MAG_W   = SUM_W;
   localparam int DIV_SHIFT = MAG_W + LOG_N;
   // floor(x / N) = (x * RECIP) >> DIV_SHIFT, exact for x below 2**MAG_W
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << DIV_SHIFT) + 64'(CALIB_SAMPLES) - 64'd1) / 64'(CALIB_SAMPLES);
   localparam logic [MAG_W:0]     RECIP     = RECIP_FULL[MAG_W:0];
   localparam logic [CNT_W-1:0]   CNT_LAST  = CNT_W'(CALIB_SAMPLES - 1);
   localparam logic [SUM_W-1:0]   N_MINUS_1 = SUM_W'(CALIB_SAMPLES - 1);
   localparam logic [ZW-1:0]      ZRUN_MAX  = '1;

   // handshake and input stage
   logic                    in_valid_ff;
   logic [adri_pkg::OPCODE_W-1:0] in_opcode_ff;
   logic signed [AW-1:0]    in_raw_ff;
   logic                    out_free;
   logic                    advance;

   // output stage
   logic                    rsp_valid_ff;
   logic signed [AW-1:0]    clean_ff, clean_in;
   logic                    stationary_ff, stationary_in;
   logic                    done_ff, done_in;

   // configuration
   logic [DW-1:0]           deadband_ff;
   logic [ZW-1:0]           zrun_limit_ff;

   // state
   logic signed [AW-1:0]    accel_last_ff, accel_last_in;
   logic signed [VW-1:0]    vel_last_ff, vel_last_in;
   logic signed [PW-1:0]    pos_last_ff, pos_last_in;
   logic [ZW-1:0]           zero_run_ff, zero_run_in;
   logic signed [AW-1:0]    offset_ff, offset_in;
   logic signed [SUM_W-1:0] calib_sum_ff, calib_sum_in;
   logic [CNT_W-1:0]        calib_cnt_ff, calib_cnt_in;

   // conditioning
   logic signed [AW:0]      cond_diff;
   logic signed [AW-1:0]    cond_sat;
   logic signed [AW:0]      cond_ext;
   logic signed [AW:0]      db_ext;
   logic signed [AW-1:0]    cond_accel;

   // integration
   logic signed [AW:0]      a_diff;
   logic signed [AW:0]      a_half;
   logic signed [VW+1:0]    v_sum;
   logic signed [VW-1:0]    v_sat;
   logic [ZW-1:0]           zrun_inc;
   logic                    is_zero;
   logic                    force_still;
   logic signed [VW-1:0]    v_cur;
   logic signed [VW-1:0]    v_base;
   logic signed [VW:0]      dv;
   logic signed [VW:0]      dv_half;
   logic signed [PW+1:0]    p_sum;
   logic signed [PW-1:0]    p_sat;

   // calibration
   logic signed [SUM_W-1:0] sum_new;
   logic [MAG_W-1:0]        sum_mag;
   logic [2*MAG_W:0]        quot_prod;
   logic [AW-1:0]           quot;
   logic signed [AW-1:0]    offset_new;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign csr_ready = 1'b1;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accel_clean = clean_ff;
   assign rsp_velocity    = vel_last_ff;
   assign rsp_position    = pos_last_ff;
   assign rsp_stationary  = stationary_ff;
   assign rsp_calib_done  = done_ff;
   assign rsp_offset_now  = offset_ff;

   // offset subtract with 16-bit saturation, then deadband
   always_comb begin
      cond_diff = {in_raw_ff[AW-1], in_raw_ff} - {offset_ff[AW-1], offset_ff};
      if (cond_diff[AW] != cond_diff[AW-1]) begin
         cond_sat = cond_diff[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
      end else begin
         cond_sat = cond_diff[AW-1:0];
      end
      cond_ext = {cond_sat[AW-1], cond_sat};
      db_ext   = {{(AW+1-DW){1'b0}}, deadband_ff};
      if (cond_ext < db_ext && cond_ext > -db_ext) begin
         cond_accel = '0;
      end else begin
         cond_accel = cond_sat;
      end
   end

   // trapezoid integration, halves truncated toward zero
   always_comb begin
      a_diff  = {cond_accel[AW-1], cond_accel} - {accel_last_ff[AW-1], accel_last_ff};
      a_half  = (a_diff + $signed({{AW{1'b0}}, a_diff[AW]})) >>> 1;
      v_sum   = {{2{vel_last_ff[VW-1]}}, vel_last_ff}
              + {{(VW+2-AW){accel_last_ff[AW-1]}}, accel_last_ff}
              + {{(VW+1-AW){a_half[AW]}}, a_half};
      if (v_sum[VW+1:VW-1] != 3'b000 && v_sum[VW+1:VW-1] != 3'b111) begin
         v_sat = v_sum[VW+1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
      end else begin
         v_sat = v_sum[VW-1:0];
      end

      zrun_inc    = (zero_run_ff == ZRUN_MAX) ? ZRUN_MAX : zero_run_ff + 1'b1;
      is_zero     = (cond_accel == '0);
      force_still = is_zero && (zrun_inc > zrun_limit_ff);
      v_base      = force_still ? '0 : vel_last_ff;
      v_cur       = is_zero ? v_base : v_sat;

      dv      = {v_cur[VW-1], v_cur} - {v_base[VW-1], v_base};
      dv_half = (dv + $signed({{VW{1'b0}}, dv[VW]})) >>> 1;
      p_sum   = {{2{pos_last_ff[PW-1]}}, pos_last_ff}
              + {{(PW+2-VW){v_base[VW-1]}}, v_base}
              + {{(PW+1-VW){dv_half[VW]}}, dv_half};
      if (p_sum[PW+1:PW-1] != 3'b000 && p_sum[PW+1:PW-1] != 3'b111) begin
         p_sat = p_sum[PW+1] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
      end else begin
         p_sat = p_sum[PW-1:0];
      end
   end

   // floor of the calibration mean; negative sums use -ceil(-s / N)
   always_comb begin
      sum_new   = calib_sum_ff + {{(SUM_W-AW){cond_accel[AW-1]}}, cond_accel};
      sum_mag   = sum_new[SUM_W-1] ? (~sum_new + 1'b1 + N_MINUS_1) : sum_new;
      quot_prod = {{(MAG_W+1){1'b0}}, sum_mag} * {{MAG_W{1'b0}}, RECIP};
      quot      = quot_prod[DIV_SHIFT +: AW];
      // the mean of in-range samples never leaves the 16-bit range
      offset_new = sum_new[SUM_W-1] ? (~quot + 1'b1) : quot;
   end

   always_comb begin
      accel_last_in = accel_last_ff;
      vel_last_in   = vel_last_ff;
      pos_last_in   = pos_last_ff;
      zero_run_in   = zero_run_ff;
      offset_in     = offset_ff;
      calib_sum_in  = calib_sum_ff;
      calib_cnt_in  = calib_cnt_ff;
      clean_in      = '0;
      stationary_in = 1'b0;
      done_in       = 1'b0;
      case (in_opcode_ff)
         adri_pkg::OP_MEASURE: begin
            clean_in      = cond_accel;
            stationary_in = force_still;
            accel_last_in = cond_accel;
            vel_last_in   = v_cur;
            pos_last_in   = p_sat;
            zero_run_in   = is_zero ? zrun_inc : '0;
         end
         adri_pkg::OP_CALIBRATE: begin
            clean_in = cond_accel;
            if (calib_cnt_ff == CNT_LAST) begin
               offset_in    = offset_new;
               calib_sum_in = '0;
               calib_cnt_in = '0;
               done_in      = 1'b1;
            end else begin
               calib_sum_in = sum_new;
               calib_cnt_in = calib_cnt_ff + 1'b1;
            end
         end
         adri_pkg::OP_CLEAR: begin
            accel_last_in = '0;
            vel_last_in   = '0;
            pos_last_in   = '0;
            zero_run_in   = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         deadband_ff   <= adri_pkg::DEADBAND_RST;
         zrun_limit_ff <= adri_pkg::ZRUN_LIMIT_RST;
         accel_last_ff <= '0;
         vel_last_ff   <= '0;
         pos_last_ff   <= '0;
         zero_run_ff   <= '0;
         offset_ff     <= '0;
         calib_sum_ff  <= '0;
         calib_cnt_ff  <= '0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               adri_pkg::CSR_DEADBAND:       deadband_ff   <= csr_wdata[DW-1:0];
               adri_pkg::CSR_ZERO_RUN_LIMIT: zrun_limit_ff <= csr_wdata[ZW-1:0];
               default: begin
               end
            endcase
         end
         if (advance) begin
            accel_last_ff <= accel_last_in;
            vel_last_ff   <= vel_last_in;
            pos_last_ff   <= pos_last_in;
            zero_run_ff   <= zero_run_in;
            offset_ff     <= offset_in;
            calib_sum_ff  <= calib_sum_in;
            calib_cnt_ff  <= calib_cnt_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_opcode_ff <= req_opcode;
         in_raw_ff    <= req_accel_raw;
      end
      if (advance) begin
         clean_ff      <= clean_in;
         stationary_ff <= stationary_in;
         done_ff       <= done_in;
      end
   end

endmodule

@@ hw/rtl/adri_checker.sv @@
// Port-level checks for the dead-reckoning integrator, bound to the top level.
module adri_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [adri_pkg::ACCEL_W-1:0] rsp_accel_clean,
   input logic signed [adri_pkg::VEL_W-1:0]   rsp_velocity,
   input logic signed [adri_pkg::POS_W-1:0]   rsp_position,
   input logic                                rsp_stationary,
   input logic                                rsp_calib_done
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_velocity) && $stable(rsp_position))
      else $error("stalled result changed");

   // a forced stop comes only from a zero measure sample
   a_still_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stationary |-> rsp_velocity == '0 && rsp_accel_clean == '0
                                      && !rsp_calib_done)
      else $error("stationary result with motion or calibration");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

endmodule

bind accel_dead_reckoning_integrator adri_checker u_adri_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_accel_clean (rsp_accel_clean),
   .rsp_velocity    (rsp_velocity),
   .rsp_position    (rsp_position),
   .rsp_stationary  (rsp_stationary),
   .rsp_calib_done  (rsp_calib_done)
);

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the accelerometer dead-reckoning integrator.
module testbench;
   localparam longint ACC_HI = (64'sd1 << (adri_pkg::ACCEL_W - 1)) - 1;
   localparam longint ACC_LO = -ACC_HI - 1;
   localparam longint VEL_HI = (64'sd1 << (adri_pkg::VEL_W - 1)) - 1;
   localparam longint VEL_LO = -VEL_HI - 1;
   localparam longint POS_HI = (64'sd1 << (adri_pkg::POS_W - 1)) - 1;
   localparam longint POS_LO = -POS_HI - 1;
   localparam logic [adri_pkg::OPCODE_W-1:0]    OP_UNUSED  = 2'd3;
   localparam logic [adri_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd2;
   localparam int RAMP_ITEMS = 20;

   typedef struct {
      logic signed [adri_pkg::ACCEL_W-1:0] accel_clean;
      logic signed [adri_pkg::VEL_W-1:0]   velocity;
      logic signed [adri_pkg::POS_W-1:0]   position;
      logic                                stationary;
      logic                                calib_done;
      logic signed [adri_pkg::ACCEL_W-1:0] offset_now;
   } nav_fix_type;

   class dead_reckoner;
      logic [adri_pkg::DEADBAND_W-1:0]     deadband;
      logic [adri_pkg::ZRUN_W-1:0]         zero_limit;
      logic signed [adri_pkg::ACCEL_W-1:0] accel_prev;
      logic signed [adri_pkg::VEL_W-1:0]   vel_prev;
      logic signed [adri_pkg::POS_W-1:0]   pos_prev;
      logic [adri_pkg::ZRUN_W-1:0]         zero_run;
      logic signed [adri_pkg::ACCEL_W-1:0] offset;
      logic signed [23:0]                  calib_acc;
      logic [7:0]                          calib_cnt;
      nav_fix_type                         expected_fixes[$];
      int unsigned failures, samples, calib_hits, stationary_hits, vel_rail, pos_rail;

      function new();
         deadband = adri_pkg::DEADBAND_RST;
         zero_limit = adri_pkg::ZRUN_LIMIT_RST;
         accel_prev = '0;
         vel_prev = '0;
         pos_prev = '0;
         zero_run = '0;
         offset = '0;
         calib_acc = '0;
         calib_cnt = '0;
         failures = 0;
         samples = 0;
         calib_hits = 0;
         stationary_hits = 0;
         vel_rail = 0;
         pos_rail = 0;
      endfunction

      static function longint clip(longint v, longint lo, longint hi);
         return (v < lo) ? lo : ((v > hi) ? hi : v);
      endfunction

      // offset removal with saturation, then deadband (|d| == deadband is kept)
      function longint conditioned(logic signed [adri_pkg::ACCEL_W-1:0] raw);
         longint d;
         d = clip(longint'(raw) - longint'(offset), ACC_LO, ACC_HI);
         if (d < longint'(deadband) && d > -longint'(deadband)) d = 0;
         return d;
      endfunction

      function void set_register(logic [adri_pkg::CSR_INDEX_W-1:0] idx,
                                 logic [adri_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            adri_pkg::CSR_DEADBAND:       deadband = data[adri_pkg::DEADBAND_W-1:0];
            adri_pkg::CSR_ZERO_RUN_LIMIT: zero_limit = data[adri_pkg::ZRUN_W-1:0];
            default: ;
         endcase
      endfunction

      function void take_sample(logic [adri_pkg::OPCODE_W-1:0] op,
                                logic signed [adri_pkg::ACCEL_W-1:0] raw);
         nav_fix_type fix;
         longint a, a_prev, v, v_prev, p, s;
         fix.accel_clean = '0;
         fix.stationary = 1'b0;
         fix.calib_done = 1'b0;
         samples++;
         case (op)
            adri_pkg::OP_MEASURE: begin
               a = conditioned(raw);
               a_prev = longint'(accel_prev);
               v_prev = longint'(vel_prev);
               v = v_prev;
               fix.accel_clean = adri_pkg::ACCEL_W'(a);
               if (a == 0) begin
                  if (zero_run != '1) zero_run++;
                  if (zero_run > zero_limit) begin
                     v = 0;
                     v_prev = 0;
                     fix.stationary = 1'b1;
                     stationary_hits++;
                  end
               end else begin
                  zero_run = '0;
                  v = clip(v_prev + a_prev + (a - a_prev) / 2, VEL_LO, VEL_HI);
               end
               p = clip(longint'(pos_prev) + v_prev + (v - v_prev) / 2, POS_LO, POS_HI);
               if (v == VEL_HI || v == VEL_LO) vel_rail++;
               if (p == POS_HI || p == POS_LO) pos_rail++;
               accel_prev = adri_pkg::ACCEL_W'(a);
               vel_prev = adri_pkg::VEL_W'(v);
               pos_prev = adri_pkg::POS_W'(p);
            end
            adri_pkg::OP_CALIBRATE: begin
               a = conditioned(raw);
               fix.accel_clean = adri_pkg::ACCEL_W'(a);
               calib_acc = 24'(longint'(calib_acc) + a);
               calib_cnt++;
               if (calib_cnt >= adri_pkg::CALIB_SAMPLES_DEF) begin
                  s = longint'(calib_acc);
                  // floor division, not truncation
                  if (s >= 0) s = s / adri_pkg::CALIB_SAMPLES_DEF;
                  else s = -((-s + adri_pkg::CALIB_SAMPLES_DEF - 1)
                             / adri_pkg::CALIB_SAMPLES_DEF);
                  offset = adri_pkg::ACCEL_W'(clip(s, ACC_LO, ACC_HI));
                  calib_acc = '0;
                  calib_cnt = '0;
                  fix.calib_done = 1'b1;
                  calib_hits++;
               end
            end
            adri_pkg::OP_CLEAR: begin
               accel_prev = '0;
               vel_prev = '0;
               pos_prev = '0;
               zero_run = '0;
            end
            default: ;
         endcase
         fix.velocity = vel_prev;
         fix.position = pos_prev;
         fix.offset_now = offset;
         expected_fixes.push_back(fix);
      endfunction

      function int outstanding();
         return expected_fixes.size();
      endfunction

      function void compare_field(string name, logic signed [63:0] want,
                                  logic signed [63:0] got);
         if (got !== want) begin
            failures++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      function void check_fix(logic signed [adri_pkg::ACCEL_W-1:0] clean,
                              logic signed [adri_pkg::VEL_W-1:0] vel,
                              logic signed [adri_pkg::POS_W-1:0] pos, logic stat, logic done,
                              logic signed [adri_pkg::ACCEL_W-1:0] ofs);
         nav_fix_type want;
         if (expected_fixes.size() == 0) begin
            failures++;
            $display("%0t: result transfer with no sample outstanding", $time);
            return;
         end
         want = expected_fixes.pop_front();
         compare_field("accel_clean", 64'(want.accel_clean), 64'(clean));
         compare_field("velocity", 64'(want.velocity), 64'(vel));
         compare_field("position", 64'(want.position), 64'(pos));
         compare_field("stationary", 64'(want.stationary), 64'(stat));
         compare_field("calib_done", 64'(want.calib_done), 64'(done));
         compare_field("offset_now", 64'(want.offset_now), 64'(ofs));
      endfunction
   endclass

   logic                                clock;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [adri_pkg::OPCODE_W-1:0]       req_opcode = adri_pkg::OP_MEASURE;
   logic signed [adri_pkg::ACCEL_W-1:0] req_accel_raw = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic signed [adri_pkg::ACCEL_W-1:0] rsp_accel_clean;
   logic signed [adri_pkg::VEL_W-1:0]   rsp_velocity;
   logic signed [adri_pkg::POS_W-1:0]   rsp_position;
   logic                                rsp_stationary;
   logic                                rsp_calib_done;
   logic signed [adri_pkg::ACCEL_W-1:0] rsp_offset_now;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [adri_pkg::CSR_INDEX_W-1:0]    csr_index = adri_pkg::CSR_DEADBAND;
   logic [adri_pkg::CSR_DATA_W-1:0]     csr_wdata = '0;

   dead_reckoner tracker;
   int burst_left = 0;
   bit steady = 1'b0;
   int settings = 1;
   int stall_mode = 0, stall_left = 0, stall_run = 0, stall_tick = 0;
   bit stall_now;

   accel_dead_reckoning_integrator dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_accel_raw(req_accel_raw),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_accel_clean(rsp_accel_clean),
      .rsp_velocity(rsp_velocity),
      .rsp_position(rsp_position),
      .rsp_stationary(rsp_stationary),
      .rsp_calib_done(rsp_calib_done),
      .rsp_offset_now(rsp_offset_now),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("Timed out with %0d results outstanding", tracker.outstanding());
      $display("FAIL");
      $finish;
   end

   // receiver back-pressure: modes of free flow, random, periodic and heavy stalling
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = int'($urandom_range(0, 3));
         stall_left = int'($urandom_range(20, 300));
      end else begin
         stall_left--;
      end
      stall_tick++;
      case (stall_mode)
         0: stall_now = 1'b0;
         1: stall_now = 1'($urandom_range(0, 1));
         2: stall_now = (stall_tick % 3 == 0);
         default: stall_now = ($urandom_range(0, 3) != 0);
      endcase
      if (stall_now && stall_run >= 6) stall_now = 1'b0;
      stall_run = stall_now ? stall_run + 1 : 0;
      rsp_stall <= stall_now;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0)
         tracker.check_fix(rsp_accel_clean, rsp_velocity, rsp_position, rsp_stationary,
                           rsp_calib_done, rsp_offset_now);
   end

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_item(logic [adri_pkg::OPCODE_W-1:0] op,
                            logic signed [adri_pkg::ACCEL_W-1:0] raw);
      int gap;
      if (!steady) begin
         if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? int'($urandom_range(40, 200))
                                                      : int'($urandom_range(1, 12));
            gap = int'($urandom_range(0, 6));
            if (gap > 0) begin
               req_valid <= 1'b0;
               req_opcode <= adri_pkg::OPCODE_W'($urandom);
               req_accel_raw <= adri_pkg::ACCEL_W'($urandom);
               repeat (gap) @(negedge clock);
            end
         end
         burst_left--;
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_accel_raw <= raw;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      tracker.take_sample(op, raw);
      @(negedge clock);
   endtask

   // leaves csr_valid high; the caller lowers it after the last write
   task automatic write_reg(logic [adri_pkg::CSR_INDEX_W-1:0] idx,
                            logic [adri_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      tracker.set_register(idx, data);
      @(negedge clock);
   endtask

   task automatic configure(int unsigned db, int unsigned lim, bit spare);
      if (spare) write_reg(CSR_UNUSED, adri_pkg::CSR_DATA_W'($urandom));
      write_reg(adri_pkg::CSR_DEADBAND, {1'($urandom), adri_pkg::DEADBAND_W'(db)});
      write_reg(adri_pkg::CSR_ZERO_RUN_LIMIT, {8'($urandom), adri_pkg::ZRUN_W'(lim)});
      csr_valid <= 1'b0;
      settings++;
   endtask

   task automatic quiesce();
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic signed [adri_pkg::ACCEL_W-1:0] pick_accel();
      int roll, v, db;
      roll = int'($urandom_range(0, 99));
      db = int'(tracker.deadband);
      if (roll < 30) return adri_pkg::ACCEL_W'($urandom);
      if (roll < 55) v = int'($urandom_range(0, 8000)) - 4000;
      else if (roll < 75) v = int'($urandom_range(0, 600)) - 300;
      else if (roll < 88)
         v = int'(tracker.offset) + ($urandom_range(0, 1) ? db : -db)
             + int'($urandom_range(0, 2)) - 1;
      else begin
         case ($urandom_range(0, 3))
            0: v = int'(ACC_HI);
            1: v = int'(ACC_LO);
            2: v = 1;
            default: v = -1;
         endcase
      end
      return adri_pkg::ACCEL_W'(tracker.clip(longint'(v), ACC_LO, ACC_HI));
   endfunction

   // a sample that lands inside the deadband after offset removal
   function automatic logic signed [adri_pkg::ACCEL_W-1:0] quiet_accel();
      int db, r;
      db = int'(tracker.deadband);
      r = (db == 0) ? 0 : int'($urandom_range(0, 2 * db - 2)) - (db - 1);
      return adri_pkg::ACCEL_W'(tracker.clip(longint'(int'(tracker.offset) + r),
                                             ACC_LO, ACC_HI));
   endfunction

   task automatic random_traffic(int n);
      int count, len, kind, center;
      count = 0;
      while (count < n) begin
         kind = int'($urandom_range(0, 99));
         if (kind < 45) begin
            len = int'($urandom_range(3, 30));
            repeat (len) send_item(adri_pkg::OP_MEASURE, pick_accel());
         end else if (kind < 57) begin
            len = int'($urandom_range(1, 20));
            repeat (len) send_item(adri_pkg::OP_MEASURE, quiet_accel());
         end else if (kind < 72) begin
            len = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 80))
                                               : adri_pkg::CALIB_SAMPLES_DEF;
            center = int'(pick_accel());
            repeat (len)
               send_item(adri_pkg::OP_CALIBRATE, adri_pkg::ACCEL_W'(tracker.clip(
                  longint'(center + int'($urandom_range(0, 64)) - 32), ACC_LO, ACC_HI)));
         end else if (kind < 82) begin
            len = int'($urandom_range(2, 15));
            send_item(adri_pkg::OP_CLEAR, adri_pkg::ACCEL_W'($urandom));
            repeat (len - 1) send_item(adri_pkg::OP_MEASURE, pick_accel());
         end else begin
            // noise: any opcode, any sample
            len = int'($urandom_range(1, 4));
            repeat (len)
               send_item(adri_pkg::OPCODE_W'($urandom), adri_pkg::ACCEL_W'($urandom));
         end
         count += len;
      end
   endtask

   // a run of back-to-back full-scale samples after pinning the offset at one rail
   task automatic ramp(logic signed [adri_pkg::ACCEL_W-1:0] bias,
                       logic signed [adri_pkg::ACCEL_W-1:0] push);
      // with deadband 0, calibrating on bias moves the offset so push clips at full scale
      while (tracker.calib_cnt != 0) send_item(adri_pkg::OP_CALIBRATE, bias);
      repeat (adri_pkg::CALIB_SAMPLES_DEF) send_item(adri_pkg::OP_CALIBRATE, bias);
      send_item(adri_pkg::OP_CLEAR, push);
      steady = 1'b1;
      repeat (RAMP_ITEMS) send_item(adri_pkg::OP_MEASURE, push);
      steady = 1'b0;
   endtask

   initial begin
      int drain;
      tracker = new();
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset settings, extremes, deadband edges, zero run, every opcode
      send_item(adri_pkg::OP_MEASURE, 16'sh7FFF);
      send_item(adri_pkg::OP_MEASURE, -16'sh8000);
      send_item(adri_pkg::OP_MEASURE, 16'sd99);
      send_item(adri_pkg::OP_MEASURE, 16'sd100);
      send_item(adri_pkg::OP_MEASURE, -16'sd100);
      send_item(adri_pkg::OP_MEASURE, -16'sd99);
      repeat (6) send_item(adri_pkg::OP_MEASURE, 16'sd0);
      send_item(adri_pkg::OP_MEASURE, 16'sd1);
      send_item(adri_pkg::OP_MEASURE, 16'sd5000);
      send_item(OP_UNUSED, 16'sh7FFF);
      send_item(adri_pkg::OP_CALIBRATE, 16'sh7FFF);
      send_item(adri_pkg::OP_CALIBRATE, -16'sh8000);
      send_item(adri_pkg::OP_CLEAR, 16'sh5555);
      send_item(adri_pkg::OP_MEASURE, -16'sd1);
      send_item(adri_pkg::OP_MEASURE, -16'sd20000);
      send_item(adri_pkg::OP_MEASURE, 16'sd20001);
      send_item(adri_pkg::OP_CLEAR, -16'sh8000);
      send_item(OP_UNUSED, -16'sh8000);
      random_traffic(100);

      for (int ph = 0; ph < 7; ph++) begin
         quiesce();
         case (ph)
            0: configure(0, 0, 1'b0);
            1: configure(32767, 255, 1'b0);
            2: configure(1, 7, 1'b0);
            3: configure($urandom_range(0, 32767), $urandom_range(0, 255), 1'b1);
            4: configure(100, 5, 1'b0);
            5: configure($urandom_range(0, 400), $urandom_range(0, 10), 1'b0);
            default: configure($urandom_range(0, 32767), $urandom_range(0, 255), 1'b0);
         endcase
         // long zero run: the run count must stick at its ceiling, not wrap
         if (ph == 2) repeat (300) send_item(adri_pkg::OP_MEASURE, quiet_accel());
         random_traffic(70);
      end

      quiesce();
      configure(0, $urandom_range(0, 255), 1'b0);
      ramp(-16'sh8000, 16'sh7FFF);
      random_traffic(30);
      quiesce();
      configure(0, $urandom_range(0, 255), 1'b0);
      ramp(16'sh7FFF, -16'sh8000);
      random_traffic(30);

      req_valid <= 1'b0;
      drain = 0;
      while (tracker.outstanding() != 0 && drain < 1000) begin
         @(negedge clock);
         drain++;
      end
      repeat (8) @(negedge clock);
      if (tracker.outstanding() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, tracker.outstanding());
         tracker.failures += tracker.outstanding();
      end

      $display("Run covered %0d samples under %0d register settings, %0d calibrations, %0d %s",
               tracker.samples, settings, tracker.calib_hits, tracker.stationary_hits,
               "stationary forcings");
      $display("Velocity held at a rail on %0d steps, position on %0d; %0d mismatches",
               tracker.vel_rail, tracker.pos_rail, tracker.failures);
      if (tracker.failures == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
